@@ design/xpt_pkg.sv @@
package xpt_pkg;

  localparam int NAME_BUFFER  = 256;
  localparam int VALUE_BUFFER = 2048;
  localparam int NAME_LEN_W   = $clog2(NAME_BUFFER);
  localparam int VALUE_LEN_W  = $clog2(VALUE_BUFFER);
  localparam int LA_DEPTH     = 9;
  localparam int LA_IDX_W     = $clog2(LA_DEPTH);
  localparam int LA_CNT_W     = $clog2(LA_DEPTH + 1);

  localparam logic [3:0] K_OPEN_NAME  = 4'd0;
  localparam logic [3:0] K_OPEN_END   = 4'd1;
  localparam logic [3:0] K_ATTR_NAME  = 4'd2;
  localparam logic [3:0] K_ATTR_VAL   = 4'd3;
  localparam logic [3:0] K_ATTR_END   = 4'd4;
  localparam logic [3:0] K_TEXT       = 4'd5;
  localparam logic [3:0] K_TEXT_END   = 4'd6;
  localparam logic [3:0] K_CLOSE_NAME = 4'd7;
  localparam logic [3:0] K_CLOSE_END  = 4'd8;
  localparam logic [3:0] K_SELF_CLOSE = 4'd9;
  localparam logic [3:0] K_DOC_END    = 4'd10;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic run;
    logic flush;
    logic flush_fin;
    logic fin_pre;
    logic fin_end;
    logic doc;
    logic done;
  } ctl_cmd_t;

  typedef struct packed {
    logic zero_byte;
    logic eot;
    logic again;
    logic flush_go;
    logic flush_done;
    logic emit_ok;
  } ctl_status_t;

  function automatic logic is_ws(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_namech(input logic [7:0] b);
    return is_letter(b) || is_digit(b) || b == 8'h5F;
  endfunction

  // entity names without the '&', first byte in the low bits
  function automatic logic [7:0] ent_char(input logic [2:0] i, input logic [3:0] j);
    logic [39:0] s;
    case (i)
      3'd0: s = {8'h00, 8'h3B, 8'h70, 8'h6D, 8'h61};
      3'd1: s = {16'h0000, 8'h3B, 8'h74, 8'h6C};
      3'd2: s = {16'h0000, 8'h3B, 8'h74, 8'h67};
      3'd3: s = {8'h3B, 8'h73, 8'h6F, 8'h70, 8'h61};
      3'd4: s = {8'h3B, 8'h74, 8'h6F, 8'h75, 8'h71};
      default: s = '0;
    endcase
    if (j < 4'd5) return s[{j[2:0], 3'b000} +: 8];
    return 8'h00;
  endfunction

  function automatic logic [3:0] ent_len(input logic [2:0] i);
    case (i)
      3'd0: return 4'd4;
      3'd1: return 4'd3;
      3'd2: return 4'd3;
      3'd3: return 4'd5;
      3'd4: return 4'd5;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic [7:0] ent_out(input logic [2:0] i);
    case (i)
      3'd0: return 8'h26;
      3'd1: return 8'h3C;
      3'd2: return 8'h3E;
      3'd3: return 8'h27;
      3'd4: return 8'h22;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] cdata_char(input logic [3:0] n);
    case (n)
      4'd0: return 8'h3C;
      4'd1: return 8'h21;
      4'd2: return 8'h5B;
      4'd3: return 8'h43;
      4'd4: return 8'h44;
      4'd5: return 8'h41;
      4'd6: return 8'h54;
      4'd7: return 8'h41;
      4'd8: return 8'h5B;
      default: return 8'h00;
    endcase
  endfunction

endpackage

@@ design/xpt_ctrl.sv @@
module xpt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  xpt_pkg::ctl_status_t sts,
  output xpt_pkg::ctl_cmd_t    cmd
);

  typedef enum logic [6:0] {
    P_IDLE    = 7'b0000001,
    P_RUN     = 7'b0000010,
    P_FLUSH   = 7'b0000100,
    P_FIN_PRE = 7'b0001000,
    P_FIN_END = 7'b0010000,
    P_DOC     = 7'b0100000,
    P_DONE    = 7'b1000000
  } phase_t;

  phase_t ph_r, ph_nxt;
  logic   fin_r, fin_nxt;
  logic   adv;

  assign in_stall = (ph_r != P_IDLE);
  assign adv = (ph_r == P_IDLE) ? in_valid : sts.emit_ok;

  always_comb begin
    cmd           = '0;
    cmd.accept    = (ph_r == P_IDLE) && adv;
    cmd.run       = (ph_r == P_RUN) && adv;
    cmd.flush     = (ph_r == P_FLUSH) && adv;
    cmd.flush_fin = fin_r;
    cmd.fin_pre   = (ph_r == P_FIN_PRE) && adv;
    cmd.fin_end   = (ph_r == P_FIN_END) && adv;
    cmd.doc       = (ph_r == P_DOC) && adv;
    cmd.done      = (ph_r == P_DONE) && adv;
  end

  always_comb begin
    ph_nxt  = ph_r;
    fin_nxt = fin_r;
    if (adv) begin
      case (ph_r)
        P_IDLE: begin
          fin_nxt = 1'b0;
          ph_nxt  = sts.zero_byte ? P_FIN_PRE : P_RUN;
        end
        P_RUN: begin
          if (sts.flush_go) ph_nxt = P_FLUSH;
          else if (sts.again) ph_nxt = P_RUN;
          else if (sts.eot) ph_nxt = P_FIN_PRE;
          else ph_nxt = P_DONE;
        end
        P_FLUSH: begin
          if (sts.flush_done) ph_nxt = fin_r ? P_FIN_END : P_RUN;
        end
        P_FIN_PRE: begin
          fin_nxt = 1'b1;
          ph_nxt  = sts.flush_go ? P_FLUSH : P_FIN_END;
        end
        P_FIN_END: ph_nxt = P_DOC;
        P_DOC:     ph_nxt = P_DONE;
        P_DONE:    ph_nxt = P_IDLE;
        default:   ph_nxt = P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= P_IDLE;
      fin_r <= 1'b0;
    end else begin
      ph_r  <= ph_nxt;
      fin_r <= fin_nxt;
    end
  end

endmodule

@@ design/xpt_datapath.sv @@
module xpt_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  xpt_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output xpt_pkg::out_item_t   out_data,
  input  xpt_pkg::ctl_cmd_t    cmd,
  output xpt_pkg::ctl_status_t sts
);

  typedef enum logic [29:0] {
    S_BETWEEN     = 30'h0000_0001,
    S_LT          = 30'h0000_0002,
    S_OPEN        = 30'h0000_0004,
    S_BANG        = 30'h0000_0008,
    S_BANG_D      = 30'h0000_0010,
    S_DECL        = 30'h0000_0020,
    S_COM         = 30'h0000_0040,
    S_COM_D1      = 30'h0000_0080,
    S_COM_D2      = 30'h0000_0100,
    S_PI          = 30'h0000_0200,
    S_PI_Q        = 30'h0000_0400,
    S_TAG_NAME    = 30'h0000_0800,
    S_TAG         = 30'h0000_1000,
    S_TAG_SLASH   = 30'h0000_2000,
    S_ATTR_NAME   = 30'h0000_4000,
    S_ATTR_EQ     = 30'h0000_8000,
    S_ATTR_Q      = 30'h0001_0000,
    S_ATTR_VAL    = 30'h0002_0000,
    S_TEXT_START  = 30'h0004_0000,
    S_CDATA_MATCH = 30'h0008_0000,
    S_TEXT        = 30'h0010_0000,
    S_CDATA       = 30'h0020_0000,
    S_CDATA_B     = 30'h0040_0000,
    S_CLOSE_START = 30'h0080_0000,
    S_CLOSE_NAME  = 30'h0100_0000,
    S_CLOSE_TAIL  = 30'h0200_0000,
    S_ENT_A       = 30'h0400_0000,
    S_CHREF_A     = 30'h0800_0000,
    S_ENT_T       = 30'h1000_0000,
    S_CHREF_T     = 30'h2000_0000
  } pstate_t;

  localparam logic [xpt_pkg::NAME_LEN_W-1:0] NAME_MAX =
    xpt_pkg::NAME_LEN_W'(xpt_pkg::NAME_BUFFER - 1);
  localparam logic [xpt_pkg::VALUE_LEN_W-1:0] VALUE_MAX =
    xpt_pkg::VALUE_LEN_W'(xpt_pkg::VALUE_BUFFER - 1);

  pstate_t                            st_r, st_nxt;
  logic [7:0]                         b_r;
  logic                               eot_r;
  logic [7:0]                         la_r [xpt_pkg::LA_DEPTH];
  logic [xpt_pkg::LA_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [xpt_pkg::LA_CNT_W-1:0]       fidx_r, fidx_nxt;
  logic [7:0]                         cref_r, cref_nxt;
  logic [xpt_pkg::NAME_LEN_W-1:0]     nl_r, nl_nxt, nl_eff;
  logic [xpt_pkg::VALUE_LEN_W-1:0]    vl_r, vl_nxt;
  xpt_pkg::out_item_t                 hold_r;
  logic                               hold_v_r;
  xpt_pkg::out_item_t                 out_r;
  logic                               out_v_r;
  logic                               out_load;

  // one pass of the parser
  logic        raw_v, name_put, name_rst, val_put, val_clr, la_wr;
  logic [3:0]  raw_kind, name_kind, val_kind;
  logic [7:0]  val_byte;
  logic        again, flush_go;
  logic        em_v;
  logic [3:0]  em_kind;
  logic [7:0]  em_byte;
  logic        out_free, emit_ok;

  // entity matcher
  logic [1:0]  ent_r;
  logic [7:0]  ent_ch;
  logic        ent_ok;
  logic [3:0]  ent_n;
  logic        attr_side;
  logic [3:0]  side_kind;
  pstate_t     back_st;

  assign attr_side = (st_r == S_ENT_A) || (st_r == S_CHREF_A);
  assign side_kind = attr_side ? xpt_pkg::K_ATTR_VAL : xpt_pkg::K_TEXT;
  assign back_st   = attr_side ? S_ATTR_VAL : S_TEXT;
  assign ent_n     = 4'(cnt_r);

  always_comb begin
    ent_r  = 2'd0;
    ent_ch = 8'h00;
    ent_ok = 1'b0;
    for (int i = 0; i < 5; i++) begin
      if (ent_r == 2'd0 && ent_n < xpt_pkg::ent_len(3'(i))) begin
        ent_ok = 1'b1;
        for (int j = 0; j < 5; j++) begin
          if (4'(j) < ent_n && la_r[j] != xpt_pkg::ent_char(3'(i), 4'(j))) ent_ok = 1'b0;
        end
        if (ent_ok && xpt_pkg::ent_char(3'(i), ent_n) == b_r) begin
          if (ent_n + 4'd1 == xpt_pkg::ent_len(3'(i))) begin
            ent_r  = 2'd2;
            ent_ch = xpt_pkg::ent_out(3'(i));
          end else begin
            ent_r = 2'd1;
          end
        end
      end
    end
  end

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    fidx_nxt  = fidx_r;
    cref_nxt  = cref_r;
    raw_v     = 1'b0;
    raw_kind  = xpt_pkg::K_DOC_END;
    name_put  = 1'b0;
    name_rst  = 1'b0;
    name_kind = xpt_pkg::K_OPEN_NAME;
    val_put   = 1'b0;
    val_clr   = 1'b0;
    val_kind  = xpt_pkg::K_TEXT;
    val_byte  = b_r;
    la_wr     = 1'b0;
    again     = 1'b0;
    flush_go  = 1'b0;

    if (cmd.run) begin
      case (st_r)
        S_BETWEEN: if (b_r == xpt_pkg::CH_LT) st_nxt = S_LT;
        S_LT: begin
          if (b_r == xpt_pkg::CH_SLASH) st_nxt = S_CLOSE_START;
          else if (b_r == xpt_pkg::CH_BANG) st_nxt = S_BANG;
          else if (b_r == xpt_pkg::CH_QMARK) st_nxt = S_PI;
          else begin
            st_nxt = S_OPEN;
            again  = 1'b1;
          end
        end
        S_OPEN: begin
          if (xpt_pkg::is_ws(b_r)) begin
          end else if (xpt_pkg::is_letter(b_r)) begin
            name_rst  = 1'b1;
            name_put  = 1'b1;
            name_kind = xpt_pkg::K_OPEN_NAME;
            st_nxt    = S_TAG_NAME;
          end else begin
            raw_v    = 1'b1;
            raw_kind = xpt_pkg::K_OPEN_END;
            st_nxt   = S_TAG;
            again    = 1'b1;
          end
        end
        S_BANG, S_BANG_D: begin
          if (b_r == xpt_pkg::CH_DASH) st_nxt = (st_r == S_BANG) ? S_BANG_D : S_COM;
          else begin
            st_nxt = S_DECL;
            again  = 1'b1;
          end
        end
        S_DECL: if (b_r == xpt_pkg::CH_GT) st_nxt = S_BETWEEN;
        S_COM: if (b_r == xpt_pkg::CH_DASH) st_nxt = S_COM_D1;
        S_COM_D1: st_nxt = (b_r == xpt_pkg::CH_DASH) ? S_COM_D2 : S_COM;
        S_COM_D2: begin
          if (b_r == xpt_pkg::CH_GT) st_nxt = S_BETWEEN;
          else if (b_r != xpt_pkg::CH_DASH) st_nxt = S_COM;
        end
        S_PI: if (b_r == xpt_pkg::CH_QMARK) st_nxt = S_PI_Q;
        S_PI_Q: begin
          if (b_r == xpt_pkg::CH_GT) st_nxt = S_BETWEEN;
          else if (b_r != xpt_pkg::CH_QMARK) st_nxt = S_PI;
        end
        S_TAG_NAME: begin
          if (xpt_pkg::is_namech(b_r)) begin
            name_put  = 1'b1;
            name_kind = xpt_pkg::K_OPEN_NAME;
          end else begin
            raw_v    = 1'b1;
            raw_kind = xpt_pkg::K_OPEN_END;
            st_nxt   = S_TAG;
            again    = 1'b1;
          end
        end
        S_TAG: begin
          if (xpt_pkg::is_ws(b_r)) begin
          end else if (b_r == xpt_pkg::CH_GT) begin
            val_clr = 1'b1;
            st_nxt  = S_TEXT_START;
          end else if (b_r == xpt_pkg::CH_SLASH) begin
            st_nxt = S_TAG_SLASH;
          end else if (xpt_pkg::is_letter(b_r)) begin
            name_rst  = 1'b1;
            name_put  = 1'b1;
            name_kind = xpt_pkg::K_ATTR_NAME;
            st_nxt    = S_ATTR_NAME;
          end else begin
            st_nxt = S_ATTR_EQ;
            again  = 1'b1;
          end
        end
        S_TAG_SLASH: begin
          if (b_r == xpt_pkg::CH_GT) begin
            raw_v    = 1'b1;
            raw_kind = xpt_pkg::K_SELF_CLOSE;
            st_nxt   = S_BETWEEN;
          end else begin
            st_nxt = S_TAG;
            again  = 1'b1;
          end
        end
        S_ATTR_NAME: begin
          if (xpt_pkg::is_namech(b_r)) begin
            name_put  = 1'b1;
            name_kind = xpt_pkg::K_ATTR_NAME;
          end else begin
            st_nxt = S_ATTR_EQ;
            again  = 1'b1;
          end
        end
        S_ATTR_EQ, S_ATTR_Q: begin
          if (xpt_pkg::is_ws(b_r)) begin
          end else if (b_r == xpt_pkg::CH_EQ && st_r == S_ATTR_EQ) begin
            st_nxt = S_ATTR_Q;
          end else if (b_r == xpt_pkg::CH_QUOTE) begin
            val_clr = 1'b1;
            st_nxt  = S_ATTR_VAL;
          end else if (b_r == xpt_pkg::CH_GT || b_r == xpt_pkg::CH_SLASH) begin
            raw_v    = 1'b1;
            raw_kind = xpt_pkg::K_ATTR_END;
            st_nxt   = S_TAG;
            again    = 1'b1;
          end else begin
            val_clr = 1'b1;
            st_nxt  = S_ATTR_VAL;
            again   = 1'b1;
          end
        end
        S_ATTR_VAL: begin
          if (b_r == xpt_pkg::CH_QUOTE) begin
            raw_v    = 1'b1;
            raw_kind = xpt_pkg::K_ATTR_END;
            st_nxt   = S_TAG;
          end else if (b_r == xpt_pkg::CH_AMP) begin
            cnt_nxt = '0;
            st_nxt  = S_ENT_A;
          end else begin
            val_put  = 1'b1;
            val_kind = xpt_pkg::K_ATTR_VAL;
          end
        end
        S_TEXT_START: begin
          if (xpt_pkg::is_ws(b_r)) begin
          end else if (b_r == xpt_pkg::CH_LT) begin
            cnt_nxt = xpt_pkg::LA_CNT_W'(1);
            st_nxt  = S_CDATA_MATCH;
          end else begin
            st_nxt = S_TEXT;
            again  = 1'b1;
          end
        end
        S_CDATA_MATCH: begin
          if (cnt_r < xpt_pkg::LA_CNT_W'(9) && b_r == xpt_pkg::cdata_char(ent_n)) begin
            if (cnt_r == xpt_pkg::LA_CNT_W'(8)) begin
              cnt_nxt = '0;
              st_nxt  = S_CDATA;
            end else begin
              cnt_nxt = cnt_r + xpt_pkg::LA_CNT_W'(1);
            end
          end else begin
            raw_v    = 1'b1;
            raw_kind = xpt_pkg::K_TEXT_END;
            cnt_nxt  = '0;
            again    = 1'b1;
            if (cnt_r <= xpt_pkg::LA_CNT_W'(1)) st_nxt = S_LT;
            else if (cnt_r == xpt_pkg::LA_CNT_W'(2)) st_nxt = S_BANG;
            else st_nxt = S_DECL;
          end
        end
        S_TEXT: begin
          if (b_r == xpt_pkg::CH_LT) begin
            raw_v    = 1'b1;
            raw_kind = xpt_pkg::K_TEXT_END;
            st_nxt   = S_LT;
          end else if (b_r == xpt_pkg::CH_AMP) begin
            cnt_nxt = '0;
            st_nxt  = S_ENT_T;
          end else begin
            val_put = 1'b1;
          end
        end
        S_CDATA: begin
          if (b_r == xpt_pkg::CH_RBRK) st_nxt = S_CDATA_B;
          else val_put = 1'b1;
        end
        S_CDATA_B: begin
          if (b_r == xpt_pkg::CH_RBRK) begin
            raw_v    = 1'b1;
            raw_kind = xpt_pkg::K_TEXT_END;
            st_nxt   = S_BETWEEN;
          end else begin
            val_put  = 1'b1;
            val_byte = xpt_pkg::CH_RBRK;
            st_nxt   = S_CDATA;
            again    = 1'b1;
          end
        end
        S_CLOSE_START: begin
          if (xpt_pkg::is_letter(b_r)) begin
            name_rst  = 1'b1;
            name_put  = 1'b1;
            name_kind = xpt_pkg::K_CLOSE_NAME;
            st_nxt    = S_CLOSE_NAME;
          end else if (b_r == xpt_pkg::CH_GT) begin
            raw_v    = 1'b1;
            raw_kind = xpt_pkg::K_CLOSE_END;
            st_nxt   = S_BETWEEN;
          end
        end
        S_CLOSE_NAME: begin
          if (xpt_pkg::is_namech(b_r)) begin
            name_put  = 1'b1;
            name_kind = xpt_pkg::K_CLOSE_NAME;
          end else if (b_r == xpt_pkg::CH_GT) begin
            raw_v    = 1'b1;
            raw_kind = xpt_pkg::K_CLOSE_END;
            st_nxt   = S_BETWEEN;
          end else begin
            st_nxt = S_CLOSE_TAIL;
          end
        end
        S_CLOSE_TAIL: begin
          if (b_r == xpt_pkg::CH_GT) begin
            raw_v    = 1'b1;
            raw_kind = xpt_pkg::K_CLOSE_END;
            st_nxt   = S_BETWEEN;
          end
        end
        S_ENT_A, S_ENT_T: begin
          val_kind = side_kind;
          if (cnt_r == '0 && b_r == xpt_pkg::CH_HASH) begin
            cref_nxt = 8'h00;
            st_nxt   = attr_side ? S_CHREF_A : S_CHREF_T;
          end else if (ent_r == 2'd2) begin
            val_put  = 1'b1;
            val_byte = ent_ch;
            cnt_nxt  = '0;
            st_nxt   = back_st;
          end else if (ent_r == 2'd1) begin
            if (cnt_r < xpt_pkg::LA_CNT_W'(xpt_pkg::LA_DEPTH)) begin
              la_wr   = 1'b1;
              cnt_nxt = cnt_r + xpt_pkg::LA_CNT_W'(1);
            end
          end else begin
            // no entity fits: '#' now, buffered letters follow, byte is re-run
            val_put  = 1'b1;
            val_byte = xpt_pkg::CH_HASH;
            flush_go = 1'b1;
          end
        end
        S_CHREF_A, S_CHREF_T: begin
          val_kind = side_kind;
          if (b_r == xpt_pkg::CH_SEMI) begin
            val_put  = 1'b1;
            val_byte = cref_r;
            st_nxt   = back_st;
          end else if (xpt_pkg::is_digit(b_r)) begin
            cref_nxt = (cref_r << 3) + (cref_r << 1) + (b_r - 8'h30);
          end
        end
        default: st_nxt = S_BETWEEN;
      endcase
    end else if (cmd.flush) begin
      val_kind = side_kind;
      if (fidx_r < cnt_r) begin
        val_put  = 1'b1;
        val_byte = la_r[fidx_r[xpt_pkg::LA_IDX_W-1:0]];
        fidx_nxt = fidx_r + xpt_pkg::LA_CNT_W'(1);
      end else begin
        fidx_nxt = '0;
        cnt_nxt  = '0;
        if (!cmd.flush_fin) st_nxt = back_st;
      end
    end else if (cmd.fin_pre) begin
      val_kind = side_kind;
      case (st_r)
        S_ENT_A, S_ENT_T: begin
          val_put  = 1'b1;
          val_byte = xpt_pkg::CH_HASH;
          flush_go = 1'b1;
        end
        S_CHREF_A, S_CHREF_T: begin
          val_put  = 1'b1;
          val_byte = cref_r;
        end
        S_CDATA_B: begin
          val_put  = 1'b1;
          val_byte = xpt_pkg::CH_RBRK;
        end
        default: ;
      endcase
    end else if (cmd.fin_end) begin
      case (st_r)
        S_TAG_NAME: begin
          raw_v    = 1'b1;
          raw_kind = xpt_pkg::K_OPEN_END;
        end
        S_ATTR_NAME, S_ATTR_EQ, S_ATTR_Q, S_ATTR_VAL, S_ENT_A, S_CHREF_A: begin
          raw_v    = 1'b1;
          raw_kind = xpt_pkg::K_ATTR_END;
        end
        S_TEXT_START, S_CDATA_MATCH, S_TEXT, S_CDATA, S_CDATA_B, S_ENT_T, S_CHREF_T: begin
          raw_v    = 1'b1;
          raw_kind = xpt_pkg::K_TEXT_END;
        end
        S_CLOSE_START, S_CLOSE_NAME, S_CLOSE_TAIL: begin
          raw_v    = 1'b1;
          raw_kind = xpt_pkg::K_CLOSE_END;
        end
        default: ;
      endcase
    end else if (cmd.doc) begin
      raw_v    = 1'b1;
      raw_kind = xpt_pkg::K_DOC_END;
      st_nxt   = S_BETWEEN;
      cnt_nxt  = '0;
      cref_nxt = 8'h00;
    end
  end

  assign nl_eff = name_rst ? '0 : nl_r;

  always_comb begin
    em_v    = 1'b0;
    em_kind = raw_kind;
    em_byte = 8'h00;
    nl_nxt  = nl_eff;
    vl_nxt  = val_clr ? '0 : vl_r;
    if (raw_v) begin
      em_v = 1'b1;
    end else if (name_put) begin
      if (nl_eff < NAME_MAX) begin
        em_v    = 1'b1;
        em_kind = name_kind;
        em_byte = b_r;
        nl_nxt  = nl_eff + 1'b1;
      end
    end else if (val_put) begin
      if (vl_r < VALUE_MAX) begin
        em_v    = 1'b1;
        em_kind = val_kind;
        em_byte = val_byte;
        vl_nxt  = vl_r + 1'b1;
      end
    end
    if (cmd.doc) begin
      nl_nxt = '0;
      vl_nxt = '0;
    end
  end

  assign out_free = !out_v_r || !out_stall;
  assign emit_ok  = !hold_v_r || out_free;
  assign out_load = hold_v_r && (em_v || cmd.done);

  assign sts.zero_byte  = (in_data.data_byte == 8'h00);
  assign sts.eot        = eot_r;
  assign sts.again      = again;
  assign sts.flush_go   = flush_go;
  assign sts.flush_done = !(fidx_r < cnt_r);
  assign sts.emit_ok    = emit_ok;

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_BETWEEN;
      cnt_r    <= '0;
      fidx_r   <= '0;
      cref_r   <= 8'h00;
      nl_r     <= '0;
      vl_r     <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      eot_r    <= 1'b0;
    end else begin
      if (cmd.accept) eot_r <= in_data.end_of_text;
      if (cmd.run || cmd.flush || cmd.fin_pre || cmd.fin_end || cmd.doc) begin
        st_r   <= st_nxt;
        cnt_r  <= cnt_nxt;
        fidx_r <= fidx_nxt;
        cref_r <= cref_nxt;
        nl_r   <= nl_nxt;
        vl_r   <= vl_nxt;
      end
      out_v_r <= out_load || (out_v_r && out_stall);
      // the newest result waits in hold until it is known whether it is the last
      if (em_v) begin
        hold_v_r <= 1'b1;
      end else if (cmd.done && hold_v_r) begin
        hold_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) b_r <= in_data.data_byte;
    if (la_wr) la_r[cnt_r[xpt_pkg::LA_IDX_W-1:0]] <= b_r;
    if (em_v) begin
      hold_r <= '{token_kind: em_kind, out_byte: em_byte, last_of_run: 1'b0};
      if (hold_v_r) out_r <= hold_r;
    end else if (cmd.done && hold_v_r) begin
      out_r <= '{token_kind: hold_r.token_kind, out_byte: hold_r.out_byte,
                 last_of_run: 1'b1};
    end
  end

endmodule

@@ design/xml_pull_tokenizer_top.sv @@
// Steps per byte: accept, one parser pass per run of the byte, then done; an entity
// flush adds a step per buffered letter and a closing step, end of document adds
// the fin_pre, fin_end and doc steps. A step after accept waits while a full hold
// register cannot move on. One byte is in work at a time, set by the control FSM.
// Each result waits in a hold register until the next one or the byte's done step,
// then moves to a one-entry output register. Reset (rst_n low, sync) clears state.
module xml_pull_tokenizer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  xpt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output xpt_pkg::out_item_t out_data
);

  xpt_pkg::ctl_cmd_t    cmd;
  xpt_pkg::ctl_status_t sts;

  xpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  xpt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ design/xpt_checker.sv @@
module xpt_props (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input xpt_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous byte still in work");

  a_doc_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_kind == xpt_pkg::K_DOC_END |-> out_data.last_of_run)
    else $error("document end not last of run");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind == xpt_pkg::K_OPEN_END ||
                  out_data.token_kind == xpt_pkg::K_ATTR_END ||
                  out_data.token_kind == xpt_pkg::K_TEXT_END ||
                  out_data.token_kind == xpt_pkg::K_CLOSE_END ||
                  out_data.token_kind == xpt_pkg::K_SELF_CLOSE ||
                  out_data.token_kind == xpt_pkg::K_DOC_END) |-> out_data.out_byte == 8'h00)
    else $error("marker result carries a byte");

endmodule

bind xml_pull_tokenizer_top xpt_props u_xpt_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
